FILE: rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CDB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CDB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/cdb_pkg.sv
// Types, constants and codes for the canopy displacement bisection unit.
package cdb_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [7:0]  LIMIT_RESET = 8'd200;
    localparam logic [31:0] LN2_Q30     = 32'd744261118;
    localparam logic [31:0] DEN_PCT     = 32'd100;
    localparam logic [31:0] DEN_TENTH   = 32'd10;
    localparam logic [6:0]  MUL_99      = 7'd99;
    localparam logic [2:0]  MUL_7       = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_VON_KARMAN = 2'd0;
    localparam logic [1:0] CFG_STABILITY  = 2'd1;
    localparam logic [1:0] CFG_ITER_LIMIT = 2'd2;

    // Solve status codes
    localparam logic [1:0] ST_DRAG    = 2'd0;
    localparam logic [1:0] ST_DEFAULT = 2'd1;
    localparam logic [1:0] ST_SLOPE   = 2'd2;
    localparam logic [1:0] ST_CLAMP   = 2'd3;

    typedef struct packed {
        logic [31:0] friction_velocity;
        logic [31:0] roughness_length;
        logic [31:0] stand_height;
        logic [23:0] attenuation;
    } t_item;

    typedef struct packed {
        logic [31:0] displacement;
        logic [1:0]  solve_status;
        logic [7:0]  iterations_used;
    } t_result;

endpackage

FILE: rtl/core/cdb_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit divisor.
module cdb_div #(
    parameter int FRAC_BITS = cdb_pkg::FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [32+FRAC_BITS-1:0] i_num,
    input  logic [31:0]             i_den,
    output logic                    o_done,
    output logic [32+FRAC_BITS-1:0] o_quot
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_num;
    logic [31:0]   r_rem;
    logic [31:0]   r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [32:0]   c_trial;
    logic          c_ge;
    logic [32:0]   c_diff;

    always_comb begin
        c_trial = {r_rem, r_num[NW-1]};
        c_ge    = (c_trial >= {1'b0, r_den});
        c_diff  = c_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CW'(NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= c_ge ? c_diff[31:0] : c_trial[31:0];
                r_num <= {r_num[NW-2:0], c_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

FILE: rtl/core/canopy_displacement_bisection_unit.sv
// Top level: canopy displacement solver with a shared multiplier and divider.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------
//  item in  | start, busy                 | i_item (t_item)
//  result   | o_valid (one-cycle strobe)  | o_result (t_result)
//  config   | i_cfg_valid, o_cfg_ready    | i_cfg_index, i_cfg_data
//
// Zero attenuation or a clamped slope-match answer: one pass of the divider from accept
// to result; any other answer without a bisection step is registered straight from idle.
// Otherwise n bisection steps run (n up to the iteration limit); each step runs one log2
// (normalize, then squaring steps) and one divide, skipped when the denominator is zero.
// Synchronous active-low reset returns the sequencer to idle and restores the config
// registers. busy stays high from an accepted word until its result strobe, except for
// words answered straight from idle; results cannot be stalled. von_karman writes are
// accepted and have no effect on d.
module canopy_displacement_bisection_unit #(
    parameter int FRAC_BITS = cdb_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  cdb_pkg::t_item  i_item,
    output logic            o_valid,
    output cdb_pkg::t_result o_result,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data
);

`include "assert_macros.svh"

    localparam int NW = 32 + FRAC_BITS;
    localparam int LW = FRAC_BITS + 6;
    localparam int TW = 34;
    localparam int MA = 35;
    localparam int MB = 33;
    localparam int PW = MA + MB;

    localparam logic [31:0] ONE_TENTH = 32'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic [63:0] QCAP      = (64'd1 << (63 - FRAC_BITS)) - 64'd1;
    localparam logic signed [LW-1:0] LOG_ZERO = {1'b1, {(LW-1){1'b0}}};
    localparam logic signed [PW-1:0] RND30 = (PW'(1) <<< 30) - PW'(1);
    localparam logic signed [PW-1:0] RNDF  = (PW'(1) <<< FRAC_BITS) - PW'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_NORM, S_SQR, S_LDONE, S_EVAL, S_LN, S_SCALE, S_SUB, S_STEP
    } t_state;

    typedef enum logic [1:0] { JOB_TOL, JOB_Q, JOB_FINAL } t_job;

    t_state r_state;
    t_job   r_job;

    // configuration
    logic signed [31:0] r_stab;
    logic [7:0]         r_limit;

    // item and solve state
    logic [31:0] r_z0, r_h, r_dv, r_d1, r_d2, r_den, r_tol;
    logic [23:0] r_a;
    logic [7:0]  r_it;
    logic [1:0]  r_status;
    logic        r_ref, r_rpos, r_rneg;
    logic        r_log_z, r_lzero;
    logic [31:0] r_lx;
    logic [4:0]  r_le, r_cnt;
    logic [FRAC_BITS-1:0] r_frac;
    logic signed [LW-1:0] r_lz, r_ld;
    logic signed [TW-1:0] r_t;
    logic signed [63:0]   r_s;
    logic [63:0]          r_q;

    // divider hookup
    logic          r_div_start;
    logic [NW-1:0] r_div_num;
    logic [31:0]   r_div_den;
    logic          div_done;
    logic [NW-1:0] div_quot;

    logic            r_valid;
    cdb_pkg::t_result r_res;

    // combinational helpers
    logic [32:0]  c_d0, c_d0s;
    logic [38:0]  c_h99;
    logic [34:0]  c_h7;
    logic [31:0]  c_den;
    logic [4:0]   c_sh;
    logic [32:0]  c_y2;
    logic signed [LW:0]   c_diff;
    logic signed [MA-1:0] c_ma;
    logic signed [MB-1:0] c_mb;
    logic signed [PW-1:0] c_prod, c_p30, c_pf;
    logic signed [TW-1:0] c_l, c_t;
    logic signed [LW-1:0] c_log;
    logic [63:0]          c_qsat;
    logic signed [63:0]   c_f, c_mag;
    logic                 c_fpos, c_fneg, c_go;
    logic [32:0]          c_mid;

    cdb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        c_d0  = ({1'b0, i_item.roughness_length} + {1'b0, i_item.stand_height}) >> 1;
        c_d0s = ({1'b0, ONE_TENTH} + {1'b0, i_item.stand_height}) >> 1;
        c_h99 = 39'(i_item.stand_height) * 39'(cdb_pkg::MUL_99);
        c_h7  = 35'(i_item.stand_height) * 35'(cdb_pkg::MUL_7);
        c_den = (r_dv < r_h) ? (r_h - r_dv) : 32'd0;
        c_sh  = 5'd16 >> r_cnt[2:0];
        c_diff = {r_ld[LW-1], r_ld} - {r_lz[LW-1], r_lz};

        // shared multiplier operand select
        case (r_state)
            S_SQR: begin
                c_ma = {3'b000, r_lx};
                c_mb = {1'b0, r_lx};
            end
            S_LN: begin
                c_ma = MA'(c_diff);
                c_mb = {1'b0, cdb_pkg::LN2_Q30};
            end
            default: begin
                c_ma = MA'(r_t);
                c_mb = {9'd0, r_a};
            end
        endcase
        c_prod = c_ma * c_mb;
        c_y2   = c_prod[63:31];

        // truncating arithmetic shifts toward zero
        c_p30 = (c_prod + (c_prod[PW-1] ? RND30 : PW'(0))) >>> 30;
        c_pf  = (c_prod + (c_prod[PW-1] ? RNDF : PW'(0))) >>> FRAC_BITS;
        c_l   = c_p30[TW-1:0];
        c_t   = c_l + {{(TW-32){r_stab[31]}}, r_stab};

        c_log  = r_lzero ? LOG_ZERO : {1'b0, r_le, r_frac};
        c_qsat = (64'(div_quot) > QCAP) ? QCAP : 64'(div_quot);

        c_f    = r_s - $signed(r_q);
        c_mag  = c_f[63] ? -c_f : c_f;
        c_fpos = !c_f[63] && (c_f != 64'sd0);
        c_fneg = c_f[63];
        c_go   = (r_it < r_limit) && (r_dv < r_h) && (r_dv > r_z0)
               && ($unsigned(c_mag) > {32'd0, r_tol});
        c_mid  = ({1'b0, r_d1} + {1'b0, r_d2}) >> 1;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stab  <= '0;
            r_limit <= cdb_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cdb_pkg::CFG_STABILITY:  r_stab  <= $signed(i_cfg_data);
                cdb_pkg::CFG_ITER_LIMIT: r_limit <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_valid     <= 1'b0;
            r_div_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_z0 <= i_item.roughness_length;
                        r_h  <= i_item.stand_height;
                        r_a  <= i_item.attenuation;
                        r_it <= '0;
                        if (i_item.attenuation == 24'd0) begin
                            r_div_num   <= NW'(c_h99);
                            r_div_den   <= cdb_pkg::DEN_PCT;
                            r_job       <= JOB_FINAL;
                            r_status    <= cdb_pkg::ST_DEFAULT;
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end else if (r_limit == 8'd0
                                     || c_d0 >= {1'b0, i_item.stand_height}
                                     || c_d0 <= {1'b0, i_item.roughness_length}) begin
                            // no bisection step; drag fails when midpoint is above H
                            if (c_d0 > {1'b0, i_item.stand_height}) begin
                                if (c_d0s > {1'b0, i_item.stand_height}) begin
                                    r_div_num   <= NW'(c_h7);
                                    r_div_den   <= cdb_pkg::DEN_TENTH;
                                    r_job       <= JOB_FINAL;
                                    r_status    <= cdb_pkg::ST_CLAMP;
                                    r_div_start <= 1'b1;
                                    r_state     <= S_DIV;
                                end else begin
                                    r_res   <= '{c_d0s[31:0], cdb_pkg::ST_SLOPE, 8'd0};
                                    r_valid <= 1'b1;
                                end
                            end else begin
                                r_res   <= '{c_d0[31:0], cdb_pkg::ST_DRAG, 8'd0};
                                r_valid <= 1'b1;
                            end
                        end else begin
                            r_div_num   <= NW'(i_item.roughness_length);
                            r_div_den   <= cdb_pkg::DEN_PCT;
                            r_job       <= JOB_TOL;
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        case (r_job)
                            JOB_TOL: begin
                                r_tol   <= div_quot[31:0];
                                r_lx    <= r_z0;
                                r_log_z <= 1'b1;
                                r_lzero <= 1'b0;
                                r_le    <= 5'd31;
                                r_cnt   <= '0;
                                r_state <= S_NORM;
                            end
                            JOB_Q: begin
                                r_q     <= c_qsat;
                                r_state <= S_SUB;
                            end
                            default: begin
                                r_res   <= '{div_quot[31:0], r_status, 8'd0};
                                r_valid <= 1'b1;
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_NORM: begin
                    if (r_cnt == 5'd0 && r_lx == 32'd0) begin
                        r_lzero <= 1'b1;
                        r_state <= S_LDONE;
                    end else begin
                        // leading-one search, halving the shift each cycle
                        if ((r_lx >> (6'd32 - {1'b0, c_sh})) == 32'd0) begin
                            r_lx <= r_lx << c_sh;
                            r_le <= r_le - c_sh;
                        end
                        if (r_cnt == 5'd4) begin
                            r_cnt   <= '0;
                            r_frac  <= '0;
                            r_state <= S_SQR;
                        end else begin
                            r_cnt <= r_cnt + 5'd1;
                        end
                    end
                end
                S_SQR: begin
                    if (c_y2[32]) begin
                        r_lx   <= c_y2[32:1];
                        r_frac <= {r_frac[FRAC_BITS-2:0], 1'b1};
                    end else begin
                        r_lx   <= c_y2[31:0];
                        r_frac <= {r_frac[FRAC_BITS-2:0], 1'b0};
                    end
                    if (r_cnt == 5'(FRAC_BITS - 1)) begin
                        r_state <= S_LDONE;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_LDONE: begin
                    if (r_log_z) begin
                        r_lz    <= c_log;
                        r_dv    <= r_z0;
                        r_ref   <= 1'b1;
                        r_state <= S_EVAL;
                    end else begin
                        r_ld    <= c_log;
                        r_state <= S_LN;
                    end
                end
                S_EVAL: begin
                    r_den   <= c_den;
                    r_lx    <= c_den;
                    r_log_z <= 1'b0;
                    r_lzero <= 1'b0;
                    r_le    <= 5'd31;
                    r_cnt   <= '0;
                    r_state <= S_NORM;
                end
                S_LN: begin
                    r_t     <= c_t;
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_s <= c_pf[63:0];
                    if (r_den == 32'd0) begin
                        r_q     <= QCAP;
                        r_state <= S_SUB;
                    end else begin
                        r_div_num   <= {r_h, {FRAC_BITS{1'b0}}};
                        r_div_den   <= r_den;
                        r_job       <= JOB_Q;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_SUB: begin
                    if (r_ref) begin
                        r_rpos  <= c_fpos;
                        r_rneg  <= c_fneg;
                        r_ref   <= 1'b0;
                        r_d1    <= r_z0;
                        r_d2    <= r_h;
                        r_state <= S_STEP;
                    end else begin
                        // same sign as reference: raise low bound; opposite: drop high
                        if ((c_fpos && r_rpos) || (c_fneg && r_rneg)) begin
                            r_d1 <= r_dv;
                        end else if ((c_fpos && r_rneg) || (c_fneg && r_rpos)) begin
                            r_d2 <= r_dv;
                        end
                        if (c_go) begin
                            r_state <= S_STEP;
                        end else begin
                            r_res   <= '{r_dv, cdb_pkg::ST_DRAG, r_it};
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_STEP: begin
                    r_it    <= r_it + 8'd1;
                    r_dv    <= c_mid[31:0];
                    r_state <= S_EVAL;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_result    = r_res;
    assign o_cfg_ready = 1'b1;

    `CDB_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy && i_item.attenuation != 24'd0 && r_limit != 8'd0 && i_item.roughness_length < i_item.stand_height - 32'd1 && i_item.stand_height > 32'd1, busy, "accepted solve did not raise busy")
    `CDB_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_valid, !busy, "result strobe while busy")
    `CDB_ASSERT_NXT(a_single_strobe, i_clk, i_rst_n, o_valid && !start, !o_valid, "result strobe held two cycles")
    `CDB_ASSERT_IMP(a_iter_zero, i_clk, i_rst_n, o_valid && o_result.solve_status != cdb_pkg::ST_DRAG, o_result.iterations_used == 8'd0, "nonzero iterations outside drag solve")

endmodule

FILE: bench/cdb_scoreboard.sv
// Scoreboard for the canopy displacement unit: displacement predictor and result check.
`timescale 1ns / 1ps

class cdb_scoreboard;
    localparam int FB = cdb_pkg::FRAC_BITS_DEF;
    localparam longint QCAP = (64'sd1 <<< (63 - FB)) - 1;
    localparam longint TENTH = ((64'sd1 <<< FB) + 5) / 10;

    longint stab;
    int unsigned step_limit;
    cdb_pkg::t_result pending_q[$];
    int errors;

    function new();
        stab = 0;
        step_limit = {24'd0, cdb_pkg::LIMIT_RESET};
        errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
        if (idx == cdb_pkg::CFG_STABILITY) begin
            stab = longint'($signed(data));
        end else if (idx == cdb_pkg::CFG_ITER_LIMIT) begin
            step_limit = {24'd0, data[7:0]};
        end
    endfunction

    // truncate toward zero
    function longint shr_tz(longint x, int s);
        longint m;
        m = (x < 0) ? -x : x;
        m = m >>> s;
        return (x < 0) ? -m : m;
    endfunction

    function longint log2_fx(longint v);
        int e;
        longint t;
        longint unsigned y;
        longint fr;
        if (v == 0) return -(64'sd32 <<< FB);
        e = 0;
        t = v;
        fr = 0;
        while (t > 1) begin
            t = t >>> 1;
            e++;
        end
        y = (e <= 31) ? (v << (31 - e)) : (v >> (e - 31));
        for (int i = 0; i < FB; i++) begin
            y = (y * y) >> 31;
            fr = fr <<< 1;
            if (y >= 64'h1_0000_0000) begin
                fr = fr | 1;
                y = y >> 1;
            end
        end
        return (longint'(e) <<< FB) | fr;
    endfunction

    function longint balance(bit drag, longint h, longint z0, longint a, longint d);
        longint den, l, q, t;
        den = (d < h) ? h - d : 0;
        l = shr_tz((log2_fx(den) - log2_fx(z0)) * longint'(cdb_pkg::LN2_Q30), 30);
        if (den == 0) q = QCAP;
        else begin
            q = (h <<< FB) / den;
            if (q > QCAP) q = QCAP;
        end
        if (drag) begin
            t = l + stab;
            return shr_tz(t * a, FB) - q;
        end
        if (a == 0) q = QCAP;
        else begin
            q = (q <<< FB) / a;
            if (q > QCAP) q = QCAP;
        end
        return l - q;
    endfunction

    function int sgn(longint x);
        return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
    endfunction

    function longint bisect(bit drag, longint lo, longint h, longint z0, longint a,
                            output int steps);
        longint d1, d2, d, tol, f, mag;
        int rs, it;
        bit begun;
        d1 = lo;
        d2 = h;
        d = (lo + h) >>> 1;
        tol = z0 / 100;
        rs = drag ? sgn(balance(1'b1, h, z0, a, lo)) : 1;
        f = 0;
        begun = 0;
        it = 0;
        while (it < step_limit && d < h && d > z0) begin
            if (begun) begin
                mag = (f < 0) ? -f : f;
                if (mag <= tol) break;
            end
            begun = 1;
            it++;
            d = (d1 + d2) >>> 1;
            f = balance(drag, h, z0, a, d);
            if (sgn(f) * rs > 0) d1 = d;
            else if (sgn(f) * rs < 0) d2 = d;
        end
        steps = it;
        return d;
    endfunction

    function void note_item(cdb_pkg::t_item w);
        longint z0, h, a, d, lo;
        int steps;
        cdb_pkg::t_result r;
        z0 = {32'd0, w.roughness_length};
        h = {32'd0, w.stand_height};
        a = {40'd0, w.attenuation};
        steps = 0;
        if (a == 0) begin
            d = h * 99 / 100;
            r.solve_status = cdb_pkg::ST_DEFAULT;
        end else begin
            d = bisect(1'b1, z0, h, z0, a, steps);
            r.solve_status = cdb_pkg::ST_DRAG;
            if (d > h) begin
                lo = (z0 <= h) ? z0 : TENTH;
                d = bisect(1'b0, lo, h, z0, a, steps);
                r.solve_status = cdb_pkg::ST_SLOPE;
                if (d > h) begin
                    d = h * 7 / 10;
                    r.solve_status = cdb_pkg::ST_CLAMP;
                end
            end
        end
        r.displacement = d[31:0];
        r.iterations_used = steps[7:0];
        pending_q.push_back(r);
    endfunction

    function void check_result(cdb_pkg::t_result got);
        cdb_pkg::t_result want;
        if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %h", got);
            return;
        end
        want = pending_q.pop_front();
        if (got.displacement !== want.displacement || got.solve_status !== want.solve_status
                || got.iterations_used !== want.iterations_used) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: d %h/%h status %0d/%0d steps %0d/%0d (want/got)",
                         want.displacement, got.displacement, want.solve_status,
                         got.solve_status, want.iterations_used, got.iterations_used);
        end
    endfunction
endclass

FILE: bench/tb_top.sv
// Top-level testbench for the canopy displacement bisection unit.
`timescale 1ns / 1ps

module tb_top;

    localparam int IDLE_LIMIT = 150000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    cdb_pkg::t_item i_item = '0;
    logic o_valid;
    cdb_pkg::t_result o_result;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    cdb_scoreboard sb = new();
    int idle_cycles = 0;

    canopy_displacement_bisection_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_valid(o_valid), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_result);
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic send_item(cdb_pkg::t_item w);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        sb.note_item(w);
    endtask

    // hold the sender until every result is back
    task automatic drain();
        start <= 0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0 || busy) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic cdb_pkg::t_item pick_item();
        cdb_pkg::t_item w;
        logic [31:0] h;
        w.friction_velocity = $urandom();
        if ($urandom_range(0, 4) == 0) begin
            w.roughness_length = $urandom() | 32'd1;
            w.stand_height = $urandom();
            w.attenuation = 24'($urandom());
            if ($urandom_range(0, 3) == 0) w.attenuation = '0;
        end else begin
            h = $urandom_range(32'h0001_0000, 32'h0028_0000);
            w.stand_height = h;
            w.roughness_length = $urandom_range(1, h / 10 + 1);
            w.attenuation = 24'($urandom_range(32'h0000_4000, 32'h0008_0000));
        end
        return w;
    endfunction

    function automatic cdb_pkg::t_item mk(logic [31:0] fv, logic [31:0] z0, logic [31:0] h,
                                          logic [23:0] a);
        cdb_pkg::t_item w;
        w.friction_velocity = fv;
        w.roughness_length = z0;
        w.stand_height = h;
        w.attenuation = a;
        return w;
    endfunction

    task automatic random_run(int n);
        for (int i = 0; i < n; i++) send_item(pick_item());
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: zero attenuation, field extremes, z0 above H, zero tolerance
        send_item(mk(32'hFFFF_FFFF, 32'h0000_1000, 32'hFFFF_FFFF, 24'h0));
        send_item(mk(32'd1, 32'd1, 32'd0, 24'h0));
        send_item(mk(32'h0001_0000, 32'd1, 32'h000A_0000, 24'hFF_FFFF));
        send_item(mk(32'h0001_0000, 32'd1, 32'hFFFF_FFFF, 24'h01_0000));
        send_item(mk(32'h0000_8000, 32'h0002_0000, 32'h0001_0000, 24'h02_0000));
        send_item(mk(32'h0000_8000, 32'hFFFF_FFFF, 32'h0001_0000, 24'd1));
        send_item(mk(32'h0000_8000, 32'h0000_1999, 32'h0014_0000, 24'h03_0000));
        send_item(mk(32'h0000_8000, 32'h0000_0100, 32'h0000_0000, 24'h00_8000));
        send_item(mk(32'h0000_8000, 32'h0000_4000, 32'h0005_0000, 24'd1));
        send_item(mk(32'h0000_8000, 32'h0000_0064, 32'h0000_0200, 24'hFF_FFFF));
        send_item(mk(32'h0000_8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h01_0000));
        random_run(30);
        drain();

        write_reg(cdb_pkg::CFG_VON_KARMAN, 32'h0000_0001);
        write_reg(cdb_pkg::CFG_STABILITY, 32'h8000_0000);
        write_reg(cdb_pkg::CFG_ITER_LIMIT, 32'd1);
        send_item(mk(32'h0001_0000, 32'h0000_1000, 32'h000A_0000, 24'h02_0000));
        random_run(15);
        drain();

        write_reg(cdb_pkg::CFG_VON_KARMAN, 32'h0000_FFFF);
        write_reg(cdb_pkg::CFG_STABILITY, 32'h7FFF_FFFF);
        write_reg(cdb_pkg::CFG_ITER_LIMIT, 32'd255);
        send_item(mk(32'h0001_0000, 32'd1, 32'h000A_0000, 24'h02_0000));
        random_run(8);
        drain();

        write_reg(cdb_pkg::CFG_STABILITY, 32'hFFFF_0000);
        write_reg(cdb_pkg::CFG_ITER_LIMIT, 32'd255);
        random_run(6);
        drain();

        for (int p = 0; p < 4; p++) begin
            write_reg(cdb_pkg::CFG_VON_KARMAN, $urandom_range(1, 65535));
            write_reg(cdb_pkg::CFG_STABILITY, $urandom_range(0, 1) ? $urandom() :
                      32'($signed($urandom_range(0, 32'h0004_0000)) - 32'h2_0000));
            write_reg(cdb_pkg::CFG_ITER_LIMIT, $urandom_range(4, 60));
            random_run(22);
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/cdb_pkg.sv
rtl/core/cdb_div.sv
rtl/core/canopy_displacement_bisection_unit.sv
bench/cdb_scoreboard.sv
bench/tb_top.sv
